// ----- src/jdm_pkg.sv -----
// Package of beat types, register indexes and constants for the joystick drive mixer.
package jdm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ZONE_THRESHOLD     = 2'd0;
    localparam logic [1:0] CFG_DIAGONAL_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_RAMP_START         = 2'd2;
    localparam logic [1:0] CFG_RAMP_STEP          = 2'd3;

    // Zone codes
    localparam logic [1:0] ZONE_VERTICAL   = 2'd0;
    localparam logic [1:0] ZONE_HORIZONTAL = 2'd1;
    localparam logic [1:0] ZONE_DIAGONAL   = 2'd2;
    localparam logic [1:0] ZONE_BRAKE      = 2'd3;

    // Power levels and mixing constants
    localparam logic [6:0] LEVEL_HALF          = 7'd50;
    localparam logic [6:0] LEVEL_THREE_QUARTER = 7'd75;
    localparam logic [6:0] LEVEL_FULL          = 7'd100;
    localparam logic [8:0] MIX_CENTRE          = 9'd128;

    // Configuration reset values
    localparam logic [6:0] RST_ZONE_THRESHOLD     = 7'd40;
    localparam logic [6:0] RST_DIAGONAL_THRESHOLD = 7'd20;
    localparam logic [6:0] RST_RAMP_START         = 7'd10;
    localparam logic [6:0] RST_RAMP_STEP          = 7'd5;

    typedef struct packed {
        logic signed [7:0] joy_x;
        logic signed [7:0] joy_y;
        logic              btn_half;
        logic              btn_full;
        logic              btn_three_quarter;
        logic              btn_ramp;
    } joy_in_t;

    typedef struct packed {
        logic signed [7:0] right_drive;
        logic signed [7:0] left_drive;
        logic [6:0]        level_now;
        logic [1:0]        zone;
    } drive_out_t;

endpackage

// ----- src/joystick_drive_mixer_top.sv -----
// Joystick drive mixer: power level selection, ramp and zone-based tank mixing.
// An accepted input beat is held in the input register, mixed, and offered from the result register.
// One beat per cycle while the receiver keeps out_ready high; input register then mixer logic into a result register.
// The power level is updated as each beat moves from the input to the result register.
// Reset (rst_n low, asynchronous): pipeline empty, power level zero,
// thresholds and ramp settings back to their defaults.
module joystick_drive_mixer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  jdm_pkg::joy_in_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output jdm_pkg::drive_out_t out_data
);
    import jdm_pkg::*;

    logic [6:0] zone_thr_reg;
    logic [6:0] diag_thr_reg;
    logic [6:0] ramp_start_reg;
    logic [6:0] ramp_step_reg;
    logic [6:0] power_level_reg;

    logic       s1_valid_reg;
    joy_in_t    s1_data_reg;
    logic       out_valid_reg;
    drive_out_t out_data_reg;

    logic       s1_advance;

    logic [6:0] base_level;
    logic [7:0] ramp_sum;
    logic [6:0] level_next;
    logic [7:0] mag_x;
    logic [7:0] mag_y;
    logic [7:0] mag_v;
    logic signed [7:0] v_sel;
    logic [8:0] factor_low;
    logic [8:0] factor_high;
    logic [15:0] prod_low;
    logic [15:0] prod_high;
    logic signed [7:0] low_drive;
    logic signed [7:0] high_drive;
    logic signed [7:0] lvl_pos;
    logic       upper_half;
    logic       left_quad;
    drive_out_t result_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_thr_reg   <= RST_ZONE_THRESHOLD;
            diag_thr_reg   <= RST_DIAGONAL_THRESHOLD;
            ramp_start_reg <= RST_RAMP_START;
            ramp_step_reg  <= RST_RAMP_STEP;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_ZONE_THRESHOLD:     zone_thr_reg   <= cfg_data;
                CFG_DIAGONAL_THRESHOLD: diag_thr_reg   <= cfg_data;
                CFG_RAMP_START:         ramp_start_reg <= cfg_data;
                CFG_RAMP_STEP:          ramp_step_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Handshake: stage one moves on when the result register is free or being taken
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Pick the base level from the buttons in priority order
    always_comb
    begin
        if (s1_data_reg.btn_half)
            base_level = LEVEL_HALF;
        else if (s1_data_reg.btn_full)
            base_level = LEVEL_FULL;
        else if (s1_data_reg.btn_three_quarter)
            base_level = LEVEL_THREE_QUARTER;
        else if (s1_data_reg.btn_ramp)
        begin
            if (power_level_reg == 7'd0)
                base_level = (ramp_start_reg > LEVEL_FULL) ? LEVEL_FULL : ramp_start_reg;
            else
                base_level = power_level_reg;
        end
        else
            base_level = 7'd0;
    end

    // Ramp up while held, saturating at full power
    always_comb
    begin
        ramp_sum = {1'b0, base_level} + {1'b0, ramp_step_reg};
        if (s1_data_reg.btn_ramp && (base_level < LEVEL_FULL))
            level_next = (ramp_sum > {1'b0, LEVEL_FULL}) ? LEVEL_FULL : ramp_sum[6:0];
        else
            level_next = base_level;
    end

    // Stick magnitudes and the gentle-turn products
    always_comb
    begin
        mag_x = s1_data_reg.joy_x[7] ? 8'(-s1_data_reg.joy_x) : s1_data_reg.joy_x;
        mag_y = s1_data_reg.joy_y[7] ? 8'(-s1_data_reg.joy_y) : s1_data_reg.joy_y;
        v_sel = (s1_data_reg.joy_x >= s1_data_reg.joy_y) ? s1_data_reg.joy_y
                                                         : s1_data_reg.joy_x;
        mag_v = v_sel[7] ? 8'(-v_sel) : v_sel;
        factor_low  = MIX_CENTRE - {1'b0, mag_v};
        factor_high = MIX_CENTRE + {1'b0, mag_v};
        prod_low    = {9'd0, base_level} * {7'd0, factor_low};
        prod_high   = {9'd0, base_level} * {7'd0, factor_high};
        upper_half  = !s1_data_reg.joy_y[7] && (s1_data_reg.joy_y != 8'sd0)
                      && (s1_data_reg.joy_x != 8'sd0);
        left_quad   = s1_data_reg.joy_x[7] && (s1_data_reg.joy_y != 8'sd0);
        low_drive   = upper_half ? $signed({1'b0, prod_low[14:8]})
                                 : 8'(-$signed({1'b0, prod_low[14:8]}));
        high_drive  = upper_half ? $signed({1'b0, prod_high[14:8]})
                                 : 8'(-$signed({1'b0, prod_high[14:8]}));
        lvl_pos     = $signed({1'b0, level_next});
    end

    // Classify the zone and mix the drives
    always_comb
    begin
        result_next.level_now   = level_next;
        result_next.right_drive = 8'sd0;
        result_next.left_drive  = 8'sd0;
        if ((mag_x < {1'b0, zone_thr_reg}) && (mag_y > {1'b0, zone_thr_reg}))
        begin
            result_next.zone = ZONE_VERTICAL;
            if (!s1_data_reg.joy_y[7] && (s1_data_reg.joy_y != 8'sd0))
                result_next.right_drive = lvl_pos;
            else
                result_next.right_drive = 8'(-lvl_pos);
            result_next.left_drive = result_next.right_drive;
        end
        else if ((mag_y < {1'b0, zone_thr_reg}) && (mag_x > {1'b0, zone_thr_reg}))
        begin
            result_next.zone = ZONE_HORIZONTAL;
            if (!s1_data_reg.joy_x[7] && (s1_data_reg.joy_x != 8'sd0))
                result_next.left_drive = lvl_pos;
            else
                result_next.right_drive = lvl_pos;
        end
        else if ((mag_y > {1'b0, diag_thr_reg}) && (mag_x > {1'b0, diag_thr_reg}))
        begin
            result_next.zone = ZONE_DIAGONAL;
            if (left_quad)
            begin
                result_next.right_drive = high_drive;
                result_next.left_drive  = low_drive;
            end
            else
            begin
                result_next.right_drive = low_drive;
                result_next.left_drive  = high_drive;
            end
        end
        else
            result_next.zone = ZONE_BRAKE;
    end

    // Pipeline control and power level state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            power_level_reg <= 7'd0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_advance)
            begin
                out_valid_reg   <= 1'b1;
                power_level_reg <= level_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: capture the input beat and hold the result beat
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
        if (s1_advance)
            out_data_reg <= result_next;
    end

endmodule

// ----- verif/tb_joystick_drive_mixer_top.sv -----
// Self-checking testbench for the joystick drive mixer: directed, register, random and backpressure tests.
module tb_joystick_drive_mixer_top;
    import jdm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int GAP_MAX     = 10;

    logic       clk;
    logic       rst_n;
    logic       cfg_wen;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    joy_in_t    in_data;
    logic       out_valid;
    logic       out_ready;
    drive_out_t out_data;

    // Mixer state and register copies kept by the testbench
    int         level_q;
    logic [6:0] zone_thr;
    logic [6:0] diag_thr;
    logic [6:0] ramp_start_val;
    logic [6:0] ramp_step_val;

    drive_out_t pending_drives[$];
    int         error_count;
    int         cycle_count;
    int         send_gap_max;
    int         recv_stall_max;
    int         hold_left;

    joystick_drive_mixer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_error(string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Predict one result beat and advance the power level
    function automatic drive_out_t mix_sample(joy_in_t s);
        drive_out_t r;
        int full_lvl;
        int x, y, a, b, t, d;
        int base, lvl, vsel, m, lo, hi, right, left;
        logic [1:0] zone_code;
        full_lvl = int'(LEVEL_FULL);
        x = int'(s.joy_x);
        y = int'(s.joy_y);
        right = 0;
        left = 0;
        if (s.btn_half)
            base = int'(LEVEL_HALF);
        else if (s.btn_full)
            base = int'(LEVEL_FULL);
        else if (s.btn_three_quarter)
            base = int'(LEVEL_THREE_QUARTER);
        else if (s.btn_ramp)
        begin
            if (level_q == 0)
                base = (int'(ramp_start_val) > full_lvl) ? full_lvl : int'(ramp_start_val);
            else
                base = level_q;
        end
        else
            base = 0;
        lvl = base;
        // Ramp up while held, saturating at full power
        if (s.btn_ramp && lvl < full_lvl)
        begin
            lvl = lvl + int'(ramp_step_val);
            if (lvl > full_lvl)
                lvl = full_lvl;
        end
        level_q = lvl;
        a = (x < 0) ? -x : x;
        b = (y < 0) ? -y : y;
        t = int'(zone_thr);
        d = int'(diag_thr);
        if (a < t && b > t)
        begin
            zone_code = ZONE_VERTICAL;
            right = (y > 0) ? lvl : -lvl;
            left = right;
        end
        else if (b < t && a > t)
        begin
            zone_code = ZONE_HORIZONTAL;
            if (x > 0)
                left = lvl;
            else
                right = lvl;
        end
        else if (b > d && a > d)
        begin
            zone_code = ZONE_DIAGONAL;
            vsel = (x >= y) ? y : x;
            m = (vsel < 0) ? -vsel : vsel;
            lo = (base * (int'(MIX_CENTRE) - m)) / 256;
            hi = (base * (int'(MIX_CENTRE) + m)) / 256;
            // Lower half drives backwards
            if (!(y > 0 && x != 0))
            begin
                lo = -lo;
                hi = -hi;
            end
            // Outer wheel takes the high side
            if (x < 0 && y != 0)
            begin
                right = hi;
                left = lo;
            end
            else
            begin
                right = lo;
                left = hi;
            end
        end
        else
            zone_code = ZONE_BRAKE;
        r.right_drive = right[7:0];
        r.left_drive  = left[7:0];
        r.level_now   = lvl[6:0];
        r.zone        = zone_code;
        return r;
    endfunction

    function automatic joy_in_t make_sample(int x, int y, logic [3:0] btns);
        joy_in_t s;
        s.joy_x = x[7:0];
        s.joy_y = y[7:0];
        {s.btn_half, s.btn_full, s.btn_three_quarter, s.btn_ramp} = btns;
        return s;
    endfunction

    // Stick position biased towards the zone and diagonal thresholds
    function automatic logic [7:0] rand_axis();
        int mode;
        int mg;
        int value;
        mode = $urandom_range(0, 3);
        case (mode)
            0: mg = $urandom_range(0, 255);
            1: mg = int'(zone_thr) + $urandom_range(0, 2) - 1;
            2: mg = int'(diag_thr) + $urandom_range(0, 2) - 1;
            default: mg = $urandom_range(0, 15);
        endcase
        if (mode == 0)
            value = mg - 128;
        else
            value = $urandom_range(0, 1) ? mg : -mg;
        return value[7:0];
    endfunction

    // Half ramp runs so the level climbs to saturation; the rest no buttons or mixed buttons
    function automatic joy_in_t rand_sample();
        int pick;
        logic [3:0] btns;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            btns = 4'b0001;
        else if (pick < 6)
            btns = 4'b0000;
        else
            btns = 4'($urandom_range(0, 15));
        return make_sample(int'($signed(rand_axis())), int'($signed(rand_axis())), btns);
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_sample(joy_in_t s);
        int gap;
        gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
        pending_drives.push_back(mix_sample(s));
    endtask

    // Drop valid and wait until every result beat has come back
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all four registers on consecutive cycles
    task automatic write_registers(logic [6:0] thr, logic [6:0] dthr,
                                   logic [6:0] start, logic [6:0] step);
        logic [6:0] vals[4];
        vals[CFG_ZONE_THRESHOLD]     = thr;
        vals[CFG_DIAGONAL_THRESHOLD] = dthr;
        vals[CFG_RAMP_START]         = start;
        vals[CFG_RAMP_STEP]          = step;
        for (int i = 0; i < 4; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_wen        <= 1'b0;
        zone_thr       = thr;
        diag_thr       = dthr;
        ramp_start_val = start;
        ramp_step_val  = step;
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
            send_sample(rand_sample());
    endtask

    // Extremes of the stick, every button, each zone and quadrant, at reset settings
    task automatic test_directed();
        send_gap_max   = GAP_MAX;
        recv_stall_max = GAP_MAX;
        send_sample(make_sample(0, 100, 4'b0000));
        send_sample(make_sample(0, 100, 4'b1000));
        send_sample(make_sample(10, -100, 4'b0100));
        send_sample(make_sample(100, 0, 4'b0010));
        send_sample(make_sample(-128, 5, 4'b0001));
        send_sample(make_sample(30, 30, 4'b0001));
        send_sample(make_sample(-30, 30, 4'b0001));
        send_sample(make_sample(-30, -30, 4'b0001));
        send_sample(make_sample(30, -30, 4'b0001));
        send_sample(make_sample(127, 127, 4'b0001));
        send_sample(make_sample(-128, -128, 4'b0001));
        send_sample(make_sample(-128, 127, 4'b0001));
        send_sample(make_sample(127, -128, 4'b0001));
        send_sample(make_sample(40, 100, 4'b0001));
        send_sample(make_sample(0, 40, 4'b0001));
        send_sample(make_sample(0, 0, 4'b0001));
        send_sample(make_sample(-100, -100, 4'b1001));
        send_sample(make_sample(100, -90, 4'b0101));
        send_sample(make_sample(-90, 100, 4'b0011));
        send_sample(make_sample(-5, -128, 4'b1111));
        send_sample(make_sample(5, 5, 4'b0000));
        send_sample(make_sample(-128, 0, 4'b0000));
        drain_pipeline();
    endtask

    // Register extremes, including oversized ramp start and step
    task automatic test_register_extremes();
        logic [27:0] settings[5];
        settings[0] = {7'd0, 7'd0, 7'd0, 7'd0};
        settings[1] = {7'd127, 7'd127, 7'd127, 7'd127};
        settings[2] = {7'd127, 7'd0, 7'd100, 7'd100};
        settings[3] = {7'd0, 7'd127, 7'd1, 7'd99};
        settings[4] = {7'd64, 7'd10, 7'd127, 7'd1};
        for (int i = 0; i < 5; i++)
        begin
            drain_pipeline();
            write_registers(settings[i][27:21], settings[i][20:14],
                            settings[i][13:7], settings[i][6:0]);
            send_gap_max   = (i == 2) ? 0 : GAP_MAX;
            recv_stall_max = (i == 3) ? 0 : GAP_MAX;
            send_random(40);
        end
        drain_pipeline();
    endtask

    // Random settings and items, with stretches of no idling on either side
    task automatic test_random();
        for (int i = 0; i < 8; i++)
        begin
            drain_pipeline();
            write_registers(7'($urandom_range(0, 127)), 7'($urandom_range(0, 60)),
                            7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            send_random(75);
        end
        drain_pipeline();
    endtask

    // Hold the receiver off while beats keep coming, so the block fills and stalls
    task automatic test_backpressure();
        write_registers(RST_ZONE_THRESHOLD, RST_DIAGONAL_THRESHOLD,
                        RST_RAMP_START, RST_RAMP_STEP);
        send_gap_max   = 0;
        recv_stall_max = GAP_MAX;
        hold_left      = 300;
        send_random(40);
        drain_pipeline();
    endtask

    // Receiver: check each accepted beat, then draw the next stall
    initial
    begin
        int stall_left;
        drive_out_t want;
        stall_left = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (out_valid && out_ready)
            begin
                if (pending_drives.size() == 0)
                    report_error("result beat with no expectation");
                else
                begin
                    want = pending_drives.pop_front();
                    if (out_data.right_drive !== want.right_drive)
                        report_error($sformatf("right_drive expected %0d got %0d",
                                               want.right_drive, out_data.right_drive));
                    if (out_data.left_drive !== want.left_drive)
                        report_error($sformatf("left_drive expected %0d got %0d",
                                               want.left_drive, out_data.left_drive));
                    if (out_data.level_now !== want.level_now)
                        report_error($sformatf("level_now expected %0d got %0d",
                                               want.level_now, out_data.level_now));
                    if (out_data.zone !== want.zone)
                        report_error($sformatf("zone expected %0d got %0d",
                                               want.zone, out_data.zone));
                end
                stall_left = (recv_stall_max == 0) ? 0 : $urandom_range(0, recv_stall_max);
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Reset, run the tests in turn, then report
    initial
    begin
        error_count    = 0;
        hold_left      = 0;
        send_gap_max   = GAP_MAX;
        recv_stall_max = GAP_MAX;
        level_q        = 0;
        zone_thr       = RST_ZONE_THRESHOLD;
        diag_thr       = RST_DIAGONAL_THRESHOLD;
        ramp_start_val = RST_RAMP_START;
        ramp_step_val  = RST_RAMP_STEP;
        rst_n     <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_register_extremes();
        test_random();
        test_backpressure();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
